### sv/epc_pkg.sv
// Package for the epoch-seconds-to-calendar block: types, constants and calendar helpers.
package epc_pkg;

    // Width of the shared subtract and compare unit
    localparam int unsigned UNIT_W = 18;

    // Widths of the reciprocal multiplier
    localparam int unsigned MUL_A_W = 25;
    localparam int unsigned MUL_B_W = 26;
    localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;

    // Constant division by reciprocal multiply. The power of two in each divisor is
    // shifted out first: 86400 = 675 << 7, 3600 = 225 << 4, 60 = 15 << 2. Each
    // reciprocal is ceil(2^shift / divisor), exact over the dividend range in use.
    localparam logic [MUL_B_W-1:0] DAY_DIVISOR    = 26'd675;
    localparam logic [MUL_B_W-1:0] HOUR_DIVISOR   = 26'd225;
    localparam logic [MUL_B_W-1:0] MINUTE_DIVISOR = 26'd15;
    localparam logic [MUL_B_W-1:0] WEEK_DIVISOR   = 26'd7;
    localparam logic [MUL_B_W-1:0] DAY_RECIP      = 26'd50903317;
    localparam logic [MUL_B_W-1:0] HOUR_RECIP     = 26'd9321;
    localparam logic [MUL_B_W-1:0] MINUTE_RECIP   = 26'd1093;
    localparam logic [MUL_B_W-1:0] WEEK_RECIP     = 26'd74899;
    localparam int unsigned        DAY_SHIFT      = 35;
    localparam int unsigned        HOUR_SHIFT     = 21;
    localparam int unsigned        MINUTE_SHIFT   = 14;
    localparam int unsigned        WEEK_SHIFT     = 19;

    // Calendar constants
    localparam logic [7:0]  FIRST_YEAR    = 8'd70;   // 1970 as years since 1900
    localparam logic [7:0]  YEAR_2100     = 8'd200;  // century year, not a leap year
    localparam logic [3:0]  LAST_MONTH    = 4'd11;
    localparam logic [8:0]  DAYS_COMMON   = 9'd365;
    localparam logic [8:0]  DAYS_LEAP     = 9'd366;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DAY_Q,
        ST_DAY_R,
        ST_HOUR_Q,
        ST_HOUR_R,
        ST_MIN_Q,
        ST_MIN_R,
        ST_WEEK_Q,
        ST_WEEK_R,
        ST_YEAR,
        ST_MONTH,
        ST_DONE
    } state_t;

    // Gregorian leap test over 1970..2106: 1900 is divisible by 4, so the low two
    // bits decide, and 2100 is the only century year in range that is not a leap
    // year (2000, divisible by 400, is one).
    function automatic logic is_leap(input logic [7:0] years_since_1900);
        return (years_since_1900[1:0] == 2'b00) && (years_since_1900 != YEAR_2100);
    endfunction

    // Length of a month in days, February depending on the leap flag
    function automatic logic [8:0] month_len(input logic [3:0] month, input logic leap);
        logic [8:0] len;
        unique case (month)
            4'd1:                     len = leap ? 9'd29 : 9'd28;
            4'd3, 4'd5, 4'd8, 4'd10:  len = 9'd30;
            default:                  len = 9'd31;
        endcase
        return len;
    endfunction

    // Weekday from days mod 7: 1970-01-01 was a Thursday
    function automatic logic [2:0] weekday_of(input logic [2:0] days_mod7);
        logic [2:0] wd;
        unique case (days_mod7)
            3'd0:    wd = 3'd4;
            3'd1:    wd = 3'd5;
            3'd2:    wd = 3'd6;
            3'd3:    wd = 3'd0;
            3'd4:    wd = 3'd1;
            3'd5:    wd = 3'd2;
            default: wd = 3'd3;
        endcase
        return wd;
    endfunction

endpackage

### sv/epc_sub.sv
// Shared subtract and compare unit of the calendar sequencer.
module epc_sub (
    input  logic [epc_pkg::UNIT_W-1:0] a,
    input  logic [epc_pkg::UNIT_W-1:0] b,
    output logic [epc_pkg::UNIT_W-1:0] diff,
    output logic                       ge
);
    import epc_pkg::*;

    logic [UNIT_W:0] wide;

    // Subtract with borrow out; no borrow means a >= b
    assign wide = {1'b0, a} - {1'b0, b};
    assign diff = wide[UNIT_W-1:0];
    assign ge   = ~wide[UNIT_W];

endmodule

### sv/epoch_seconds_to_calendar.sv
// Top level: converts unsigned epoch seconds to broken-down UTC calendar time.
//
//  channel | dir | payload                                        | handshake
//  --------+-----+------------------------------------------------+----------------------
//  s_      | in  | epoch_seconds[31:0]                            | s_tvalid / s_tready
//  m_      | out | second, minute, hour, year-1900, yday, month,  | m_tvalid / m_tready
//          |     | day of month, weekday                          |
//
//  An accepted beat first splits off one day, one hour, one minute and seven days by
//  reciprocal multiply (quotient, then remainder), then walks the whole years past 1970
//  (0..136) and the whole months into the year (0..11) on the shared 18-bit subtract
//  unit. s_tready is high only while the sequencer is idle; a finished result sits in
//  the output register and the next beat is taken while it waits. If the output
//  register is still full when a result is ready, the sequencer holds until it drains.
//  aresetn (synchronous, active low) clears the sequencer and the output valid.
module epoch_seconds_to_calendar (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] epoch_seconds
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // [5:0] second, [11:6] minute, [16:12] hour,
                                   // [24:17] years_since_1900, [33:25] day_of_year,
                                   // [37:34] month_index, [42:38] day_of_month,
                                   // [45:43] weekday, [47:46] zero
);
    import epc_pkg::*;

    state_t      state_reg, state_next;
    logic [31:0] work_reg, work_next;
    logic [15:0] quo_reg, quo_next;
    logic [15:0] days_reg, days_next;
    logic [7:0]  year_reg, year_next;
    logic [3:0]  month_reg, month_next;
    logic [8:0]  yday_reg, yday_next;
    logic [4:0]  hour_reg, hour_next;
    logic [5:0]  minute_reg, minute_next;
    logic [5:0]  second_reg, second_next;
    logic [2:0]  wday_reg, wday_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [47:0] m_tdata_reg, m_tdata_next;

    logic               s_accept;
    logic               out_free;
    logic               leap;
    logic [UNIT_W-1:0]  unit_a, unit_b, unit_diff;
    logic               unit_ge;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [PROD_W-1:0]  prod;
    logic [8:0]         len_year, len_month;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign leap      = is_leap(year_reg);
    assign len_year  = leap ? DAYS_LEAP : DAYS_COMMON;
    assign len_month = month_len(month_reg, leap);

    // Route operands to the multiplier: reciprocal first, then quotient times divisor
    always_comb begin
        unique case (state_reg)
            ST_DAY_Q: begin
                mul_a = work_reg[31:7];
                mul_b = DAY_RECIP;
            end
            ST_HOUR_Q: begin
                mul_a = {12'd0, work_reg[16:4]};
                mul_b = HOUR_RECIP;
            end
            ST_MIN_Q: begin
                mul_a = {15'd0, work_reg[11:2]};
                mul_b = MINUTE_RECIP;
            end
            ST_WEEK_Q: begin
                mul_a = {9'd0, days_reg};
                mul_b = WEEK_RECIP;
            end
            ST_DAY_R: begin
                mul_a = {9'd0, quo_reg};
                mul_b = DAY_DIVISOR;
            end
            ST_HOUR_R: begin
                mul_a = {9'd0, quo_reg};
                mul_b = HOUR_DIVISOR;
            end
            ST_MIN_R: begin
                mul_a = {9'd0, quo_reg};
                mul_b = MINUTE_DIVISOR;
            end
            ST_WEEK_R: begin
                mul_a = {9'd0, quo_reg};
                mul_b = WEEK_DIVISOR;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // Route operands to the shared unit; remainders need only the low bits
    always_comb begin
        unique case (state_reg)
            ST_DAY_R: begin
                unit_a = {8'd0, work_reg[16:7]};
                unit_b = {8'd0, prod[9:0]};
            end
            ST_HOUR_R: begin
                unit_a = {10'd0, work_reg[11:4]};
                unit_b = {10'd0, prod[7:0]};
            end
            ST_MIN_R: begin
                unit_a = {14'd0, work_reg[5:2]};
                unit_b = {14'd0, prod[3:0]};
            end
            ST_WEEK_R: begin
                unit_a = {15'd0, days_reg[2:0]};
                unit_b = {15'd0, prod[2:0]};
            end
            ST_YEAR: begin
                unit_a = {2'b00, days_reg};
                unit_b = {9'd0, len_year};
            end
            ST_MONTH: begin
                unit_a = {2'b00, days_reg};
                unit_b = {9'd0, len_month};
            end
            default: begin
                unit_a = '0;
                unit_b = '0;
            end
        endcase
    end

    epc_sub u_sub (
        .a    (unit_a),
        .b    (unit_b),
        .diff (unit_diff),
        .ge   (unit_ge)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_accept) state_next = ST_DAY_Q;
            ST_DAY_Q:  state_next = ST_DAY_R;
            ST_DAY_R:  state_next = ST_HOUR_Q;
            ST_HOUR_Q: state_next = ST_HOUR_R;
            ST_HOUR_R: state_next = ST_MIN_Q;
            ST_MIN_Q:  state_next = ST_MIN_R;
            ST_MIN_R:  state_next = ST_WEEK_Q;
            ST_WEEK_Q: state_next = ST_WEEK_R;
            ST_WEEK_R: state_next = ST_YEAR;
            ST_YEAR:   if (!unit_ge) state_next = ST_MONTH;
            ST_MONTH:  if (!unit_ge || month_reg == LAST_MONTH) state_next = ST_DONE;
            ST_DONE:   if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Datapath and output updates
    always_comb begin
        work_next     = work_reg;
        quo_next      = quo_reg;
        days_next     = days_reg;
        year_next     = year_reg;
        month_next    = month_reg;
        yday_next     = yday_reg;
        hour_next     = hour_reg;
        minute_next   = minute_reg;
        second_next   = second_reg;
        wday_next     = wday_reg;
        m_tdata_next  = m_tdata_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    work_next = s_tdata;
                end
            end
            // Take each quotient from the top of the reciprocal product
            ST_DAY_Q:  quo_next = prod[DAY_SHIFT +: 16];
            ST_HOUR_Q: quo_next = prod[HOUR_SHIFT +: 16];
            ST_MIN_Q:  quo_next = prod[MINUTE_SHIFT +: 16];
            ST_WEEK_Q: quo_next = prod[WEEK_SHIFT +: 16];
            // Rebuild each remainder from its low bits and the shifted-out bits
            ST_DAY_R: begin
                days_next = quo_reg;
                work_next = {15'd0, unit_diff[9:0], work_reg[6:0]};
            end
            ST_HOUR_R: begin
                hour_next = quo_reg[4:0];
                work_next = {20'd0, unit_diff[7:0], work_reg[3:0]};
            end
            ST_MIN_R: begin
                minute_next = quo_reg[5:0];
                second_next = {unit_diff[3:0], work_reg[1:0]};
            end
            ST_WEEK_R: begin
                wday_next = weekday_of(unit_diff[2:0]);
                year_next = FIRST_YEAR;
            end
            ST_YEAR: begin
                // Take off a whole year while the days left cover it
                if (unit_ge) begin
                    days_next = unit_diff[15:0];
                    year_next = year_reg + 8'd1;
                end else begin
                    yday_next  = days_reg[8:0];
                    month_next = '0;
                end
            end
            ST_MONTH: begin
                // Take off a whole month; December absorbs the rest
                if (unit_ge && month_reg != LAST_MONTH) begin
                    days_next  = unit_diff[15:0];
                    month_next = month_reg + 4'd1;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {2'b00, wday_reg, days_reg[4:0] + 5'd1, month_reg,
                                     yday_reg, year_reg, hour_reg, minute_reg, second_reg};
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        work_reg    <= work_next;
        quo_reg     <= quo_next;
        days_reg    <= days_next;
        year_reg    <= year_next;
        month_reg   <= month_next;
        yday_reg    <= yday_next;
        hour_reg    <= hour_next;
        minute_reg  <= minute_next;
        second_reg  <= second_next;
        wday_reg    <= wday_next;
        m_tdata_reg <= m_tdata_next;
    end

    // An accepted beat starts the day division on the captured seconds
    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (state_reg == ST_DAY_Q) && (work_reg == $past(s_tdata)))
        else $error("day division did not start after accept");

    // The year walk never passes 2106
    a_year_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MONTH) |-> (year_reg <= 8'd206))
        else $error("year out of range");

    // The month walk stops within December and leaves under a month of days
    a_month_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE) |-> (month_reg <= LAST_MONTH) && (days_reg < 16'd31))
        else $error("month walk overran");

    // A result is only loaded when the output register can take it
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tready) |=> m_tvalid_reg && $stable(m_tdata_reg))
        else $error("pending result overwritten");

endmodule
